// ----- hdl/ar2pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// ar2pcd_pkg
// Shared widths, register indexes and controller/datapath handshake types
// for the second-order prediction change detector.
// ----------------------------------------------------------------------------
package ar2pcd_pkg;

   // fixed field widths
   localparam int SAMPLE_W   = 16;   // signed Q1.15 sample
   localparam int COEFF_W    = 16;   // signed Q2.14 predictor coefficient
   localparam int LEN_REG_W  = 7;    // window length register
   localparam int THR_W      = 36;   // unsigned Q6.30 threshold
   localparam int INDEX_W    = 16;   // reported window index
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int E29_W      = 34;   // unrounded error, Q.29
   localparam int ERR_W      = 19;   // rounded error, Q1.15 with headroom
   localparam int SQ_W       = 36;   // squared error, Q6.30
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 36;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd2;

   // register reset values
   localparam logic [LEN_REG_W-1:0] WINDOW_LEN_RESET = 7'd8;

   // controller to datapath commands
   typedef struct packed {
      logic accept;   // input transfer this cycle
      logic do_err;   // form rounded prediction error, remove oldest term
      logic do_sqr;   // square the error
      logic do_sum;   // add square to window sum, write ring
      logic fin;      // compare, bookkeeping and result
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic cnt_ovf;  // record already at the sample limit
      logic warm;     // fewer than two samples taken in this record
      logic last;     // held item closes the record
      logic rsp_busy; // result register full and stalled
   } status_type;

endpackage

// ----- hdl/ar2pcd_ram.sv -----
// ----------------------------------------------------------------------------
// ar2pcd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ar2pcd_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ar2pcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ar2pcd_ctrl
// Sequencer for one sample: accept, error, square, sum update, finish.
// ----------------------------------------------------------------------------
module ar2pcd_ctrl import ar2pcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ERR  = 5'b00010,
      ST_SQR  = 5'b00100,
      ST_SUM  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      fin_go;

   // finishing waits only when a result is due and the output is still held
   assign fin_go = !(status.last && status.rsp_busy);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (status.cnt_ovf || status.warm) ? ST_FIN : ST_ERR;
            end
         end
         ST_ERR:  state_in = ST_SQR;
         ST_SQR:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_FIN;
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign req_stall  = (state_ff != ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.do_err = (state_ff == ST_ERR);
   assign cmd.do_sqr = (state_ff == ST_SQR);
   assign cmd.do_sum = (state_ff == ST_SUM);
   assign cmd.fin    = (state_ff == ST_FIN) && fin_go;

   // a computing sample goes through the arithmetic states
   a_compute_path: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && !status.cnt_ovf && !status.warm |=> state_ff == ST_ERR)
      else $error("computing sample skipped the error state");

   // a due result is never dropped while the output is held
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN && status.last && status.rsp_busy |=> state_ff == ST_FIN)
      else $error("finish left while result register was stalled");

   // finishing always returns to accept the next sample
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> state_ff == ST_IDLE)
      else $error("finish did not return to idle");

endmodule

// ----- hdl/ar2pcd_datapath.sv -----
// ----------------------------------------------------------------------------
// ar2pcd_datapath
// Configuration registers, predictor and squarer, error ring with running
// window sum, hit tracking and the result register.
// ----------------------------------------------------------------------------
module ar2pcd_datapath import ar2pcd_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cmd_type                     cmd,
   output status_type                  status,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_last_sample,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [INDEX_W-1:0]          rsp_first_index,
   output logic [INDEX_W-1:0]          rsp_last_index,
   output logic                        rsp_found,
   output logic                        rsp_too_long
);

   localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = SQ_W + LEN_W;
   localparam int CMP_B  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int CMP_W  = ((CMP_B > INDEX_W) ? CMP_B : INDEX_W) + 1;

   // configuration registers
   logic signed [COEFF_W-1:0]  coeff_ff, coeff_in;
   logic [LEN_REG_W-1:0]       window_len_ff, window_len_in;
   logic [THR_W-1:0]           thr_ff, thr_in;

   // record state
   logic signed [SAMPLE_W-1:0] prev1_ff, prev1_in;
   logic signed [SAMPLE_W-1:0] prev2_ff, prev2_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [AW-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [INDEX_W-1:0]         first_hit_ff, first_hit_in;
   logic [INDEX_W-1:0]         last_hit_ff, last_hit_in;
   logic                       hit_seen_ff, hit_seen_in;
   logic                       overflowed_ff, overflowed_in;
   logic [LEN_W-1:0]           active_len_ff, active_len_in;

   // per-sample working registers
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic                       last_ff, last_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [SUM_W-1:0]           thr_len_ff, thr_len_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic [SUM_W-1:0]           sub_ff, sub_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]         rsp_first_ff, rsp_first_in;
   logic [INDEX_W-1:0]         rsp_last_ff, rsp_last_in;
   logic                       rsp_found_ff, rsp_found_in;
   logic                       rsp_too_long_ff, rsp_too_long_in;

   // combinational helpers
   logic [LEN_W-1:0]           len_clamped;
   logic [LEN_W-1:0]           len_use;
   logic signed [PROD_W-1:0]   prod_full;
   logic [SUM_W-1:0]           thr_len_full;
   logic [SAMPLE_W:0]          pair_sum;
   logic [E29_W-1:0]           e29;
   logic signed [2*ERR_W-1:0]  sq_full;
   logic [LEN_W:0]             ptr_x, len_x, rd_wide;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              ptr_next;
   logic [SQ_W-1:0]            ram_rd_data;
   logic [CMP_W-1:0]           cnt_c, len_c, idx_c;
   logic                       rd_ok, win_full, cur_ovf, compute, hit;
   logic [INDEX_W-1:0]         first_nx, last_nx;
   logic                       seen_nx, ovf_nx;

   // window length clamp: zero means one, long saturates
   always_comb begin
      if (window_len_ff == '0) begin
         len_clamped = LEN_W'(1);
      end else if (int'(window_len_ff) > MAX_WINDOW) begin
         len_clamped = LEN_W'(MAX_WINDOW);
      end else begin
         len_clamped = LEN_W'(window_len_ff);
      end
   end

   // length is latched at the first sample of a record
   assign len_use      = (count_ff == '0) ? len_clamped : active_len_ff;
   assign prod_full    = coeff_ff * prev1_ff;
   assign thr_len_full = SUM_W'(thr_ff) * SUM_W'(len_use);

   // prediction error c*x1 - (x2 + x) * 2^14, rounded half up to Q1.15
   assign pair_sum = {prev2_ff[SAMPLE_W-1], prev2_ff} + {x_ff[SAMPLE_W-1], x_ff};
   assign e29 = {{(E29_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff}
              - {{(E29_W-SAMPLE_W-15){pair_sum[SAMPLE_W]}}, pair_sum, 14'b0}
              + E29_W'(8192);
   assign sq_full = err_ff * err_ff;

   // ring addresses: oldest term sits len entries behind the write pointer
   assign ptr_x = (LEN_W+1)'(wr_ptr_ff);
   assign len_x = (LEN_W+1)'(active_len_ff);
   always_comb begin
      if (ptr_x >= len_x) begin
         rd_wide = ptr_x - len_x;
      end else begin
         rd_wide = ptr_x + (LEN_W+1)'(MAX_WINDOW) - len_x;
      end
   end
   assign rd_addr  = rd_wide[AW-1:0];
   assign ptr_next = (wr_ptr_ff == AW'(MAX_WINDOW - 1)) ? '0 : wr_ptr_ff + 1'b1;

   // window position checks against the sample count
   assign cnt_c    = CMP_W'(count_ff);
   assign len_c    = CMP_W'(active_len_ff);
   assign rd_ok    = cnt_c >= len_c + CMP_W'(2);
   assign win_full = cnt_c >= len_c + CMP_W'(1);
   assign idx_c    = cnt_c - len_c - CMP_W'(1) + (len_c >> 1);
   assign cur_ovf  = count_ff >= CNT_W'(MAX_SAMPLES);
   assign compute  = !cur_ovf && (count_ff >= CNT_W'(2));
   assign hit      = compute && win_full && (sum_ff <= thr_len_ff);

   // hit tracking including the current sample
   assign first_nx = (hit && !hit_seen_ff) ? idx_c[INDEX_W-1:0] : first_hit_ff;
   assign last_nx  = hit ? idx_c[INDEX_W-1:0] : last_hit_ff;
   assign seen_nx  = hit_seen_ff || hit;
   assign ovf_nx   = overflowed_ff || cur_ovf;

   // error ring
   ar2pcd_ram #(
      .WIDTH (SQ_W),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.do_sum),
      .wr_addr (wr_ptr_ff),
      .wr_data (sq_ff),
      .rd_en   (cmd.accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // next values
   always_comb begin
      coeff_in        = coeff_ff;
      window_len_in   = window_len_ff;
      thr_in          = thr_ff;
      prev1_in        = prev1_ff;
      prev2_in        = prev2_ff;
      count_in        = count_ff;
      wr_ptr_in       = wr_ptr_ff;
      sum_in          = sum_ff;
      first_hit_in    = first_hit_ff;
      last_hit_in     = last_hit_ff;
      hit_seen_in     = hit_seen_ff;
      overflowed_in   = overflowed_ff;
      active_len_in   = active_len_ff;
      x_in            = x_ff;
      last_in         = last_ff;
      prod_in         = prod_ff;
      thr_len_in      = thr_len_ff;
      err_in          = err_ff;
      sub_in          = sub_ff;
      sq_in           = sq_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_first_in    = rsp_first_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_too_long_in = rsp_too_long_ff;

      // configuration writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_COEFF:      coeff_in      = csr_wdata[COEFF_W-1:0];
            CSR_WINDOW_LEN: window_len_in = csr_wdata[LEN_REG_W-1:0];
            CSR_THRESHOLD:  thr_in        = csr_wdata[THR_W-1:0];
            default:        coeff_in      = coeff_ff;
         endcase
      end

      // input transfer: capture sample, first multiply, threshold scaling
      if (cmd.accept) begin
         x_in       = req_sample;
         last_in    = req_last_sample;
         prod_in    = prod_full;
         thr_len_in = thr_len_full;
         if (count_ff == '0) begin
            active_len_in = len_clamped;
         end
      end

      // rounded error and window sum without the oldest term
      if (cmd.do_err) begin
         err_in = e29[ERR_W+13:14];
         sub_in = sum_ff - (rd_ok ? SUM_W'(ram_rd_data) : '0);
      end

      if (cmd.do_sqr) begin
         sq_in = sq_full[SQ_W-1:0];
      end

      if (cmd.do_sum) begin
         sum_in = sub_ff + SUM_W'(sq_ff);
      end

      // finish: bookkeeping, then result and record clear on the last sample
      if (cmd.fin) begin
         first_hit_in  = first_nx;
         last_hit_in   = last_nx;
         hit_seen_in   = seen_nx;
         overflowed_in = ovf_nx;
         if (!cur_ovf) begin
            prev2_in = prev1_ff;
            prev1_in = x_ff;
            count_in = count_ff + 1'b1;
         end
         if (compute) begin
            wr_ptr_in = ptr_next;
         end
         if (last_ff) begin
            rsp_valid_in    = 1'b1;
            rsp_first_in    = seen_nx ? first_nx : '0;
            rsp_last_in     = seen_nx ? last_nx : '0;
            rsp_found_in    = seen_nx;
            rsp_too_long_in = ovf_nx;
            prev1_in        = '0;
            prev2_in        = '0;
            count_in        = '0;
            wr_ptr_in       = '0;
            sum_in          = '0;
            first_hit_in    = '0;
            last_hit_in     = '0;
            hit_seen_in     = 1'b0;
            overflowed_in   = 1'b0;
            active_len_in   = LEN_W'(1);
         end
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff      <= '0;
         window_len_ff <= WINDOW_LEN_RESET;
         thr_ff        <= '0;
         prev1_ff      <= '0;
         prev2_ff      <= '0;
         count_ff      <= '0;
         wr_ptr_ff     <= '0;
         sum_ff        <= '0;
         first_hit_ff  <= '0;
         last_hit_ff   <= '0;
         hit_seen_ff   <= 1'b0;
         overflowed_ff <= 1'b0;
         active_len_ff <= LEN_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         coeff_ff      <= coeff_in;
         window_len_ff <= window_len_in;
         thr_ff        <= thr_in;
         prev1_ff      <= prev1_in;
         prev2_ff      <= prev2_in;
         count_ff      <= count_in;
         wr_ptr_ff     <= wr_ptr_in;
         sum_ff        <= sum_in;
         first_hit_ff  <= first_hit_in;
         last_hit_ff   <= last_hit_in;
         hit_seen_ff   <= hit_seen_in;
         overflowed_ff <= overflowed_in;
         active_len_ff <= active_len_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      last_ff         <= last_in;
      prod_ff         <= prod_in;
      thr_len_ff      <= thr_len_in;
      err_ff          <= err_in;
      sub_ff          <= sub_in;
      sq_ff           <= sq_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_too_long_ff <= rsp_too_long_in;
   end

   // status to the controller
   assign status.cnt_ovf  = cur_ovf;
   assign status.warm     = count_ff < CNT_W'(2);
   assign status.last     = last_ff;
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_index = rsp_first_ff;
   assign rsp_last_index  = rsp_last_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_too_long    = rsp_too_long_ff;

   // sample count saturates at the record limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count passed the record limit");

   // hit indexes stay clear until a window qualifies
   a_hits_clear: assert property (@(posedge clock) disable iff (reset)
      !hit_seen_ff |-> first_hit_ff == '0 && last_hit_ff == '0)
      else $error("hit index set without a qualifying window");

   // closing a record starts the next one clean
   a_record_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.fin && last_ff |=> count_ff == '0 && sum_ff == '0 && !hit_seen_ff && rsp_valid_ff)
      else $error("record not cleared after result");

endmodule

// ----- hdl/ar2_prediction_change_detector_unit.sv -----
// ----------------------------------------------------------------------------
// ar2_prediction_change_detector_unit
// Second-order linear prediction error detector, top level.
// ----------------------------------------------------------------------------
// Samples enter on the req_ channel (valid/stall); one result per record
// leaves on the rsp_ channel, produced by the sample marked req_last_sample.
// The csr_ port writes the predictor coefficient, window length and energy
// threshold; writes are taken any cycle, but belong between records.
// Each sample passes through the coefficient multiply at transfer, rounding
// of the error, squaring, and the ring read-modify-write of the window sum,
// then a finish step compares and updates; the next sample waits for it.
// The first two samples of a record and samples past MAX_SAMPLES skip the
// arithmetic and go straight to the finish step.
// The result is valid in the cycle after the finish cycle of the last
// sample and sits in an output register; the next record's samples are
// accepted meanwhile. If that register is still stalled when another record
// closes, the finish cycle waits and req_stall stays high.
// Reset clears all record state and the configuration registers (window
// length 8); the ring needs no clearing since only entries written in the
// current record are read.
// ----------------------------------------------------------------------------
module ar2_prediction_change_detector_unit import ar2pcd_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int MAX_SAMPLES = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [INDEX_W-1:0]         rsp_first_index,
   output logic [INDEX_W-1:0]         rsp_last_index,
   output logic                       rsp_found,
   output logic                       rsp_too_long,
   input  logic                       csr_write_en,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   ar2pcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, ring and result register
   ar2pcd_datapath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_first_index (rsp_first_index),
      .rsp_last_index  (rsp_last_index),
      .rsp_found       (rsp_found),
      .rsp_too_long    (rsp_too_long)
   );

endmodule

// ----- verif/ar2_prediction_change_detector_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ar2_prediction_change_detector_unit_tb
// Self-checking bench for the second-order prediction change detector.
// ----------------------------------------------------------------------------
// A clocked driver sends samples from a queue with random gaps, and a clocked
// monitor stalls the result channel at random. Every accepted sample runs
// through a detector model kept in the bench, and each record result is
// compared field by field with the oldest expected report. A directed
// section covers sample extremes, window length zero, a length change
// inside an open record, the unused register index and single-sample
// records. Random phases follow with tracking, noisy and extreme signals
// and window lengths up to and above the maximum.
// ----------------------------------------------------------------------------
module ar2_prediction_change_detector_unit_tb import ar2pcd_pkg::*;;

   localparam int MAX_WINDOW    = 64;
   localparam int MAX_SAMPLES   = 65536;
   localparam int RANDOM_ITEMS  = 700;
   localparam int DRAIN_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 20;

   // unused register slot, writes must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum {SIG_TRACK, SIG_NOISE, SIG_EXTREME} signal_kind_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_sample;
   } sample_item_type;

   typedef struct {
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] last_index;
      logic               found;
      logic               too_long;
   } report_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   // block ports
   logic                       req_valid       = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample      = '0;
   logic                       req_last_sample = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall       = 1'b0;
   logic [INDEX_W-1:0]         rsp_first_index;
   logic [INDEX_W-1:0]         rsp_last_index;
   logic                       rsp_found;
   logic                       rsp_too_long;
   logic                       csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index       = '0;
   logic [CSR_DATA_W-1:0]      csr_wdata       = '0;

   ar2_prediction_change_detector_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_first_index (rsp_first_index),
      .rsp_last_index  (rsp_last_index),
      .rsp_found       (rsp_found),
      .rsp_too_long    (rsp_too_long),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // bench bookkeeping
   sample_item_type sample_q[$];
   report_type      expected_reports[$];
   int              items_queued   = 0;
   int              items_accepted = 0;
   int              err_count      = 0;
   bit              no_idle        = 1'b0;
   int              send_gap       = 0;
   int              stall_left     = 0;
   sample_item_type next_item;
   report_type      want;

   // detector model: configuration
   logic signed [COEFF_W-1:0] det_coeff = '0;
   logic [LEN_REG_W-1:0]      det_wlen  = WINDOW_LEN_RESET;
   logic [THR_W-1:0]          det_thr   = '0;

   // detector model: record state
   logic signed [SAMPLE_W-1:0] rec_p1    = '0;
   logic signed [SAMPLE_W-1:0] rec_p2    = '0;
   int                         rec_count = 0;
   longint unsigned            rec_ring [MAX_WINDOW] = '{default: 0};
   longint unsigned            rec_sum   = 0;
   logic [INDEX_W-1:0]         rec_first = '0;
   logic [INDEX_W-1:0]         rec_last  = '0;
   bit                         rec_hit   = 1'b0;
   bit                         rec_ovf   = 1'b0;
   int                         rec_len   = 1;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      err_count++;
   endtask

   // effective window length: zero reads as one, saturate at the ring size
   function automatic int window_of(input logic [LEN_REG_W-1:0] w);
      if (w == 0) return 1;
      if (w > MAX_WINDOW) return MAX_WINDOW;
      return int'(w);
   endfunction

   // idle length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // advance the detector by one accepted sample, queue a report at record end
   task automatic step_detector(input logic signed [SAMPLE_W-1:0] x, input logic last);
      longint          e29;
      longint          err;
      longint unsigned sq;
      longint unsigned bound;
      int              k;
      report_type      rep;
      if (rec_count >= MAX_SAMPLES) begin
         rec_ovf = 1'b1;
      end else begin
         if (rec_count == 0) rec_len = window_of(det_wlen);
         if (rec_count >= 2) begin
            k   = rec_count - 2;
            // exact Q.29 error, then round half up to Q1.15
            e29 = longint'(det_coeff) * longint'(rec_p1)
                - (longint'(rec_p2) + longint'(x)) * 16384;
            err = (e29 + 8192) >>> 14;
            sq  = err * err;
            if (k >= rec_len) rec_sum -= rec_ring[(k - rec_len) % MAX_WINDOW];
            rec_ring[k % MAX_WINDOW] = sq;
            rec_sum += sq;
            // full window: compare sum against threshold times length
            if (k + 1 >= rec_len) begin
               bound = det_thr;
               bound = bound * rec_len;
               if (rec_sum <= bound) begin
                  if (!rec_hit) rec_first = INDEX_W'((k + 1 - rec_len) + rec_len / 2);
                  rec_last = INDEX_W'((k + 1 - rec_len) + rec_len / 2);
                  rec_hit  = 1'b1;
               end
            end
         end
         rec_p2 = rec_p1;
         rec_p1 = x;
         rec_count++;
      end
      if (last) begin
         rep.first_index = rec_hit ? rec_first : '0;
         rep.last_index  = rec_hit ? rec_last : '0;
         rep.found       = rec_hit;
         rep.too_long    = rec_ovf;
         expected_reports.insert(expected_reports.size(), rep);
         rec_p1    = '0;
         rec_p2    = '0;
         rec_count = 0;
         rec_sum   = 0;
         rec_first = '0;
         rec_last  = '0;
         rec_hit   = 1'b0;
         rec_ovf   = 1'b0;
         rec_len   = 1;
      end
   endtask

   // input driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid       <= 1'b0;
         req_sample      <= '0;
         req_last_sample <= 1'b0;
         send_gap = 0;
      end else begin
         // transfer completed at this edge
         if (req_valid && !req_stall) begin
            step_detector(req_sample, req_last_sample);
            items_accepted++;
         end
         // slot free: idle or present the next sample
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
               next_item = sample_q.pop_front();
               req_valid       <= 1'b1;
               req_sample      <= next_item.sample;
               req_last_sample <= next_item.last_sample;
               send_gap = no_idle ? 0 : pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("result transfer with no report expected");
            end else begin
               want = expected_reports.pop_front();
               if (rsp_first_index !== want.first_index)
                  report_mismatch($sformatf("first_index got %0d want %0d",
                                            rsp_first_index, want.first_index));
               if (rsp_last_index !== want.last_index)
                  report_mismatch($sformatf("last_index got %0d want %0d",
                                            rsp_last_index, want.last_index));
               if (rsp_found !== want.found)
                  report_mismatch($sformatf("found got %0b want %0b",
                                            rsp_found, want.found));
               if (rsp_too_long !== want.too_long)
                  report_mismatch($sformatf("too_long got %0b want %0b",
                                            rsp_too_long, want.too_long));
            end
         end
         if (no_idle) begin
            rsp_stall <= 1'b0;
            stall_left = 0;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   // register write, model follows at once since the block is idle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_COEFF:      det_coeff = val[COEFF_W-1:0];
         CSR_WINDOW_LEN: det_wlen  = val[LEN_REG_W-1:0];
         CSR_THRESHOLD:  det_thr   = val[THR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic push_item(input int x, input bit last);
      sample_item_type it;
      it.sample      = x[SAMPLE_W-1:0];
      it.last_sample = last;
      sample_q.insert(sample_q.size(), it);
      items_queued++;
   endtask

   // wait for every sample to transfer and every report to arrive, then settle
   task automatic wait_idle();
      int waited = 0;
      while (items_accepted != items_queued) @(posedge clock);
      while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      while (expected_reports.size() != 0) begin
         report_mismatch("expected report never arrived");
         void'(expected_reports.pop_front());
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one record (or part of one) of generated samples
   task automatic queue_record(input int n, input signal_kind_type kind, input bit close);
      int a, b, x, amp, noise_amp;
      amp       = (1 << $urandom_range(0, 15)) - 1;
      noise_amp = (1 << $urandom_range(0, 12)) - 1;
      a = int'($urandom_range(0, 2 * amp)) - amp;
      b = int'($urandom_range(0, 2 * amp)) - amp;
      for (int i = 0; i < n; i++) begin
         case (kind)
            // follow the predictor recursion, small noise on top
            SIG_TRACK: begin
               x = ((int'(det_coeff) * a + 8192) >>> 14) - b
                 + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
               if (x > 32767) x = 32767;
               if (x < -32768) x = -32768;
            end
            SIG_NOISE: x = int'($urandom_range(0, 65535)) - 32768;
            default: begin
               case ($urandom_range(0, 4))
                  0: x = 32767;
                  1: x = -32768;
                  2: x = 0;
                  3: x = -1;
                  default: x = 1;
               endcase
            end
         endcase
         b = a;
         a = x;
         push_item(x, close && (i == n - 1));
      end
   endtask

   // stimulus sequence
   initial begin : stimulus
      int                    start_items, nrec, len, n, part, w, r;
      logic [CSR_DATA_W-1:0] val;
      longint unsigned       mask;
      signal_kind_type       kind;
      bit                    split;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, record too short for a full window
      push_item(32767, 1'b0);
      push_item(-32768, 1'b0);
      push_item(0, 1'b0);
      push_item(-32768, 1'b1);
      wait_idle();

      // window length zero, threshold at maximum, most negative coefficient
      write_reg(CSR_WINDOW_LEN, 36'h0);
      write_reg(CSR_THRESHOLD, 36'hF_FFFF_FFFF);
      write_reg(CSR_COEFF, 36'h0_0000_8000);
      write_reg(CSR_SPARE, {4'($urandom_range(0, 15)), $urandom});
      push_item(-32768, 1'b0);
      push_item(32767, 1'b0);
      push_item(-32768, 1'b0);
      push_item(32767, 1'b0);
      push_item(0, 1'b1);
      // single-sample record
      push_item(12345, 1'b1);
      wait_idle();

      // silent record, every window hits at zero threshold
      write_reg(CSR_WINDOW_LEN, 36'h2);
      write_reg(CSR_THRESHOLD, 36'h0);
      write_reg(CSR_COEFF, 36'h0_0000_7FFF);
      repeat (5) push_item(0, 1'b0);
      push_item(0, 1'b1);
      wait_idle();

      // length change inside an open record applies to the next one
      write_reg(CSR_COEFF, 36'h0);
      write_reg(CSR_THRESHOLD, 36'h0_0010_0000);
      push_item(100, 1'b0);
      push_item(200, 1'b0);
      wait_idle();
      write_reg(CSR_WINDOW_LEN, 36'h3);
      push_item(300, 1'b0);
      push_item(-400, 1'b0);
      push_item(500, 1'b0);
      push_item(-600, 1'b1);
      wait_idle();

      // random phases
      start_items = items_queued;
      while (items_queued < start_items + RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       val = {20'($urandom), 16'h8000};
            1:       val = {20'($urandom), 16'h7FFF};
            2:       val = {20'($urandom), 16'h0000};
            default: val = {20'($urandom), 16'($urandom)};
         endcase
         write_reg(CSR_COEFF, val);

         val = {4'($urandom_range(0, 15)), $urandom};
         case ($urandom_range(0, 9))
            0:       val[LEN_REG_W-1:0] = 7'd0;
            1:       val[LEN_REG_W-1:0] = 7'd1;
            2:       val[LEN_REG_W-1:0] = 7'd64;
            3:       val[LEN_REG_W-1:0] = 7'd127;
            4:       val[LEN_REG_W-1:0] = 7'($urandom_range(65, 126));
            5:       val[LEN_REG_W-1:0] = 7'($urandom_range(17, 63));
            default: val[LEN_REG_W-1:0] = 7'($urandom_range(2, 16));
         endcase
         write_reg(CSR_WINDOW_LEN, val);

         case ($urandom_range(0, 5))
            0:       val = '0;
            1:       val = '1;
            default: begin
               w    = $urandom_range(0, 36);
               mask = (64'd1 << w) - 1;
               val  = CSR_DATA_W'({$urandom_range(0, 15), $urandom} & mask);
            end
         endcase
         write_reg(CSR_THRESHOLD, val);

         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_SPARE, {4'($urandom_range(0, 15)), $urandom});

         no_idle = ($urandom_range(0, 3) == 0);
         len     = window_of(det_wlen);
         nrec    = $urandom_range(1, (len > 16) ? 2 : 5);
         split   = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < nrec; i++) begin
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, len + 1);
            else n = len + 2 + $urandom_range(0, 24);
            r = $urandom_range(0, 9);
            kind = (r < 6) ? SIG_TRACK : (r < 8) ? SIG_NOISE : SIG_EXTREME;
            if (split && i == nrec - 1 && n >= 2) begin
               // open record, idle, new window length, then finish it
               part = $urandom_range(1, n - 1);
               queue_record(part, kind, 1'b0);
               wait_idle();
               write_reg(CSR_WINDOW_LEN, {4'($urandom_range(0, 15)), $urandom});
               queue_record(n - part, kind, 1'b1);
            end else begin
               queue_record(n, kind, 1'b1);
            end
         end
         wait_idle();
      end

      // short closing phase with idling back on
      no_idle = 1'b0;
      write_reg(CSR_WINDOW_LEN, 36'h5);
      queue_record(12, SIG_TRACK, 1'b1);
      wait_idle();

      if (err_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // run limit
   initial begin
      #80_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
